// ===== rtl/bsdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded signed decimal parser package
// Shared constants, phase encoding and the item, result and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package bsdp_pkg;

	localparam int CHAR_W        = 8;
	localparam int VALUE_W       = 32;
	localparam int DIGIT_COUNT_W = 16;
	localparam int COUNT_WIDTH   = 16;
	localparam int MAG_EXT_W     = VALUE_W + 3;
	localparam int DIGIT_W       = 4;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	localparam logic [MAG_EXT_W-1:0] LIMIT_POS = MAG_EXT_W'(32'h7FFF_FFFF);
	localparam logic [MAG_EXT_W-1:0] LIMIT_NEG = MAG_EXT_W'(32'h8000_0000);

	typedef enum logic [2:0] {
		PH_IDLE       = 3'b001,
		PH_NEED_DIGIT = 3'b010,
		PH_DIGITS     = 3'b100
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              window_start;
		logic              window_end;
		logic              empty_window;
	} item_t;

	typedef struct packed {
		logic                     parse_ok;
		logic [VALUE_W-1:0]       parsed_value;
		logic [DIGIT_COUNT_W-1:0] digit_count;
	} result_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   negative_sign;
		logic [VALUE_W-1:0]     magnitude;
		logic [COUNT_WIDTH-1:0] digits_seen;
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_signed_decimal_parser.sv =====
// ----------------------------------------------------------------------------
// Bounded signed decimal parser
// Parses an optionally signed decimal number from a byte window into int32.
// ----------------------------------------------------------------------------
// The block takes one byte item per clock while the result register is free
// or being emptied, and gives at most one result item per window. An accepted
// item is held in an input register; from there, once the result register is
// free or being emptied, the multiply by ten, the add and the limit compare
// update the parse state and load the result register, which drives the
// master side.
`default_nettype none

module bounded_signed_decimal_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic [1:0]  s_tuser,   // window_start, empty_window
	input  logic        s_tlast,   // window_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // parsed_value, digit_count
	output logic [0:0]  m_tuser    // parse_ok
);
	import bsdp_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_next;
	logic    emit;
	result_t result;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.char_code    <= s_tdata;
			item_s1.window_start <= s_tuser[0];
			item_s1.window_end   <= s_tlast;
			item_s1.empty_window <= s_tuser[1];
		end
	end

	bsdp_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.state_next (state_next),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.negative_sign <= 1'b0;
			state_q.magnitude     <= '0;
			state_q.digits_seen   <= '0;
			out_valid_q           <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.digit_count, res_q.parsed_value};
	assign m_tuser  = res_q.parse_ok;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !advance)
		else $error("Result register advanced while a result was stalled.");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> state_q.phase == PH_IDLE)
		else $error("Parser did not return to idle after a result.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.parse_ok |-> res_q.parsed_value == '0 && res_q.digit_count == '0)
		else $error("Failure result carries a nonzero value or count.");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.magnitude <= 32'h8000_0000)
		else $error("Magnitude exceeded its bound.");

endmodule

`default_nettype wire

// ===== rtl/bsdp_step.sv =====
// ----------------------------------------------------------------------------
// Bounded signed decimal parser step
// Next state and optional result for one item, from the current parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdp_step (
	input  bsdp_pkg::item_t   item,
	input  bsdp_pkg::state_t  state,
	output bsdp_pkg::state_t  state_next,
	output logic              emit,
	output bsdp_pkg::result_t result
);
	import bsdp_pkg::*;

	state_t                 work;
	logic                   is_digit;
	logic                   is_sign;
	logic                   scan;
	logic                   give_ok;
	logic                   give_err;
	logic [MAG_EXT_W-1:0]   mag_ext;
	logic [MAG_EXT_W-1:0]   cand;
	logic [MAG_EXT_W-1:0]   limit;
	logic [DIGIT_W-1:0]     digit;
	logic [VALUE_W-1:0]     signed_mag;

	always_comb begin
		is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
		is_sign  = (item.char_code == CHAR_PLUS) || (item.char_code == CHAR_MINUS);
		digit    = item.char_code[DIGIT_W-1:0];
		work     = state;
		scan     = 1'b0;
		give_ok  = 1'b0;
		give_err = 1'b0;

		if (item.empty_window) begin
			work.negative_sign = 1'b0;
			work.magnitude     = '0;
			work.digits_seen   = '0;
			give_err           = 1'b1;
		end else if (item.window_start) begin
			work.negative_sign = (item.char_code == CHAR_MINUS);
			work.magnitude     = '0;
			work.digits_seen   = '0;
			work.phase         = PH_NEED_DIGIT;
			if (is_sign) begin
				give_err = item.window_end;
			end else begin
				scan = 1'b1;
			end
		end else begin
			unique case (state.phase)
				PH_NEED_DIGIT, PH_DIGITS: scan = 1'b1;
				default:                  work.phase = PH_IDLE;
			endcase
		end

		mag_ext = MAG_EXT_W'(work.magnitude);
		cand    = (mag_ext << 3) + (mag_ext << 1) + MAG_EXT_W'(digit);
		limit   = work.negative_sign ? LIMIT_NEG : LIMIT_POS;

		if (scan) begin
			if (!is_digit) begin
				if (work.phase == PH_DIGITS) begin
					give_ok = 1'b1;
				end else begin
					give_err = 1'b1;
				end
			end else if (cand > limit) begin
				give_err = 1'b1;
			end else begin
				work.magnitude = cand[VALUE_W-1:0];
				if (work.digits_seen != {COUNT_WIDTH{1'b1}}) begin
					work.digits_seen = work.digits_seen + 1'b1;
				end
				work.phase = PH_DIGITS;
				give_ok    = item.window_end;
			end
		end

		signed_mag = work.negative_sign ? (VALUE_W'(0) - work.magnitude) : work.magnitude;

		emit   = give_ok || give_err;
		result = '0;
		if (give_ok) begin
			result.parse_ok     = 1'b1;
			result.parsed_value = signed_mag;
			result.digit_count  = DIGIT_COUNT_W'(work.digits_seen);
		end
		if (emit) begin
			work.phase = PH_IDLE;
		end
		state_next = work;
	end

endmodule

`default_nettype wire

// ===== tb/parse_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parse result checker
// Watches both streams of the decimal parser, keeps its own copy of the parse
// state, predicts the result of every window and compares each result item
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module parse_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic [1:0]  s_tuser,   // window_start, empty_window
	input  logic        s_tlast,   // window_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // parsed_value, digit_count
	input  logic [0:0]  m_tuser,   // parse_ok
	output int          mismatch_count,
	output int          results_pending
);
	import bsdp_pkg::*;

	phase_t                 window_phase;
	logic                   negative;
	logic [VALUE_W-1:0]     magnitude;
	logic [COUNT_WIDTH-1:0] digit_total;
	result_t                expected_results[$];
	int                     errors;

	task automatic clear_window_state();
		negative = 1'b0;
		magnitude = '0;
		digit_total = '0;
	endtask

	task automatic finish_window(input bit ok);
		result_t r;
		r = '0;
		if (ok) begin
			r.parse_ok = 1'b1;
			r.parsed_value = negative ? -magnitude : magnitude;
			r.digit_count = DIGIT_COUNT_W'(digit_total);
		end
		expected_results.push_back(r);
		window_phase = PH_IDLE;
	endtask

	task automatic predict_parse(input item_t it);
		logic [VALUE_W-1:0] digit;
		logic [VALUE_W-1:0] limit;
		bit                 is_digit;
		bit                 is_sign;
		bit                 consumed;
		is_digit = it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE;
		is_sign = it.char_code == CHAR_PLUS || it.char_code == CHAR_MINUS;
		digit = VALUE_W'(it.char_code - CHAR_ZERO);
		consumed = 1'b0;
		if (it.empty_window) begin
			clear_window_state();
			finish_window(1'b0);
			consumed = 1'b1;
		end else if (it.window_start) begin
			clear_window_state();
			window_phase = PH_NEED_DIGIT;
			if (is_sign) begin
				negative = it.char_code == CHAR_MINUS;
				consumed = 1'b1;
				if (it.window_end) begin
					finish_window(1'b0);
				end
			end
		end else if (window_phase == PH_IDLE) begin
			consumed = 1'b1;
		end
		if (!consumed) begin
			if (!is_digit) begin
				// A non-digit after digits closes the window with success.
				finish_window(window_phase == PH_DIGITS);
			end else begin
				limit = negative ? VALUE_W'(LIMIT_NEG) : VALUE_W'(LIMIT_POS);
				if (magnitude > (limit - digit) / 10) begin
					finish_window(1'b0);
				end else begin
					magnitude = magnitude * 10 + digit;
					if (digit_total != '1) begin
						digit_total++;
					end
					window_phase = PH_DIGITS;
					if (it.window_end) begin
						finish_window(1'b1);
					end
				end
			end
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("unexpected result: ok=%0b value=%0d count=%0d",
					got.parse_ok, $signed(got.parsed_value), got.digit_count);
			end
		end else begin
			want = expected_results.pop_front();
			if (got.parse_ok !== want.parse_ok || got.parsed_value !== want.parsed_value
					|| got.digit_count !== want.digit_count) begin
				errors++;
				if (errors <= 10) begin
					$display("result mismatch: expected ok=%0b value=%0d count=%0d, got ok=%0b value=%0d count=%0d",
						want.parse_ok, $signed(want.parsed_value), want.digit_count,
						got.parse_ok, $signed(got.parsed_value), got.digit_count);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_window_state();
			window_phase = PH_IDLE;
			expected_results.delete();
			errors = 0;
			mismatch_count <= 0;
			results_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result({m_tuser[0], m_tdata[31:0], m_tdata[47:32]});
			end
			if (s_tvalid && s_tready) begin
				predict_parse({s_tdata, s_tuser[0], s_tlast, s_tuser[1]});
			end
			mismatch_count <= errors;
			results_pending <= expected_results.size();
		end
	end

endmodule

// ===== tb/bounded_signed_decimal_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded signed decimal parser testbench
// Sends directed and random byte windows with random gaps and stalls on both
// streams and holds the result side off long enough to fill the block. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module bounded_signed_decimal_parser_tb;

	import bsdp_pkg::*;

	localparam int HOLD_CYCLES      = 300;
	localparam int DIRECTED_ITEMS   = 25;
	localparam int RANDOM_ITEMS     = 700;
	localparam int SETTLE_CYCLES    = 10;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;
	int          mismatch_count;
	int          results_pending;
	bit          idle_on;
	bit          hold_request;
	int          items_sent;
	int          windows_sent;

	bounded_signed_decimal_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	parse_result_checker parse_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("bounded_signed_decimal_parser_tb NOT OK");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			m_tready <= !idle_on || $urandom_range(0, 99) >= 14;
		end
	end

	task automatic send_byte(input logic [7:0] code, input bit opens, input bit closes,
			input bit empty);
		if (idle_on && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		s_tuser <= {empty, opens};
		s_tlast <= closes;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string text, input bit closes);
		for (int i = 0; i < text.len(); i++) begin
			send_byte(text[i], i == 0, closes && i == text.len() - 1, 1'b0);
		end
	endtask

	function automatic logic [7:0] pick_non_digit();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
		return c;
	endfunction

	function automatic logic [7:0] pick_sign();
		return $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
	endtask

	task automatic send_number_window();
		longint unsigned v;
		string           text;
		int              ending;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom_range(0, 999);
			4, 5: v = $urandom;
			6, 7: v = 64'd2147483640 + $urandom_range(0, 15);
			8: v = {$urandom, $urandom} % 64'd100000000000;
			default: v = $urandom_range(0, 9);
		endcase
		text = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) text = {"0", text};
		end
		case ($urandom_range(0, 2))
			0: text = {"-", text};
			1: text = {"+", text};
			default: ;
		endcase
		ending = $urandom_range(0, 9);
		send_text(text, ending < 5);
		if (ending >= 5 && ending < 9) begin
			send_byte(pick_non_digit(), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
			repeat ($urandom_range(0, 3)) begin
				send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
			end
		end
	endtask

	task automatic send_random_window();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
		end else if (kind < 16) begin
			repeat ($urandom_range(1, 4)) begin
				send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
					$urandom_range(0, 15) == 0);
			end
		end else if (kind < 24) begin
			case ($urandom_range(0, 3))
				0: send_byte(pick_sign(), 1'b1, 1'b1, 1'b0);
				1: begin
					send_byte(pick_sign(), 1'b1, 1'b0, 1'b0);
					send_byte(pick_non_digit(), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
				end
				2: send_byte(pick_non_digit(), 1'b1, 1'($urandom_range(0, 1)), 1'b0);
				default: begin
					send_text($sformatf("%0d", $urandom_range(0, 999)), 1'b0);
					send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'b1);
				end
			endcase
		end else begin
			send_number_window();
		end
	endtask

	task automatic run_directed();
		send_byte(8'h00, 1'b0, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1, 1'b0);
		send_byte(8'h41, 1'b1, 1'b1, 1'b1);
		send_text("-2147483648", 1'b1);
		send_text("-", 1'b1);
		send_text("+x", 1'b0);
		send_text("7a", 1'b0);
		send_text("x", 1'b0);
		send_text("12", 1'b0);
		send_text("3", 1'b1);
		send_text("+5", 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		items_sent = 0;
		windows_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			idle_on = !(items_sent >= 250 && items_sent < 420);
			if (windows_sent == 40) begin
				hold_request = 1'b1;
				repeat (40) send_text($sformatf("%0d", $urandom_range(0, 99999)), 1'b1);
			end
			if (windows_sent == 80) begin
				wait_drained();
			end
			send_random_window();
			windows_sent++;
		end
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("bounded_signed_decimal_parser_tb OK");
		end else begin
			$display("bounded_signed_decimal_parser_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bsdp_pkg.sv
rtl/bsdp_step.sv
rtl/bounded_signed_decimal_parser.sv
tb/parse_result_checker.sv
tb/bounded_signed_decimal_parser_tb.sv
